/* design/door_lock_controller_fsm_top_macros.svh */
// ============================================================================
// Door lock controller assertion macros
// Concurrent assertion shorthands. Synthesis builds see empty bodies.
// ============================================================================
`ifndef DOOR_LOCK_CONTROLLER_FSM_TOP_MACROS_SVH
`define DOOR_LOCK_CONTROLLER_FSM_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define DLC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("door lock controller: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("door lock controller: next-cycle check failed");

`else

`define DLC_ASSERT_SAME(label, ante, cons)
`define DLC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/dlc_pkg.sv */
// ============================================================================
// Door lock controller package
// Codes, widths, reset values and the controller state record.
// ============================================================================
package dlc_pkg;

    localparam int STATE_W = 4;
    localparam int CMD_W   = 4;
    localparam int PHASE_W = 2;
    localparam int DELAY_W = 16;
    localparam int MODE_W  = 3;
    localparam int ACT_W   = 2;
    localparam int FAIL_W  = 3;

    // Controller states
    localparam logic [STATE_W-1:0] ST_INIT      = 4'd0;
    localparam logic [STATE_W-1:0] ST_OPENED    = 4'd1;
    localparam logic [STATE_W-1:0] ST_CLOSED    = 4'd2;
    localparam logic [STATE_W-1:0] ST_OPENING   = 4'd3;
    localparam logic [STATE_W-1:0] ST_CLOSING   = 4'd4;
    localparam logic [STATE_W-1:0] ST_WANT      = 4'd5;
    localparam logic [STATE_W-1:0] ST_RETRY     = 4'd6;
    localparam logic [STATE_W-1:0] ST_CALIB     = 4'd7;
    localparam logic [STATE_W-1:0] ST_WARN      = 4'd8;
    localparam logic [STATE_W-1:0] ST_FATAL     = 4'd9;
    localparam logic [STATE_W-1:0] ST_MAN_OPEN  = 4'd10;
    localparam logic [STATE_W-1:0] ST_MAN_CLOSE = 4'd11;

    // Motor commands
    localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_UNFREEZE  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_OPEN      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CAL_OPEN  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CAL_ABORT = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CAL       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CAL_DONE  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REV_CLOSE = 4'd8;
    localparam logic [CMD_W-1:0] CMD_REV_OPEN  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_MAN_OPEN  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_MAN_CLOSE = 4'd11;
    localparam logic [CMD_W-1:0] CMD_MAN_END   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_REVOKE    = 4'd13;
    localparam logic [CMD_W-1:0] CMD_FREEZE    = 4'd14;

    // Event kinds
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DOOR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOCK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MOTOR = 3'd5;

    // Button and switch actions
    localparam logic [ACT_W-1:0] ACT_SHORT    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LONG     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SUPER    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASED = 2'd3;

    // Motor results
    localparam logic [FAIL_W-1:0] FAIL_NONE        = 3'd0;
    localparam logic [FAIL_W-1:0] FAIL_CALIB       = 3'd1;
    localparam logic [FAIL_W-1:0] FAIL_DRIVER      = 3'd2;
    localparam logic [FAIL_W-1:0] FAIL_HALL_SILENT = 3'd3;
    localparam logic [FAIL_W-1:0] FAIL_STEP_LOSS   = 3'd4;
    localparam logic [FAIL_W-1:0] FAIL_MOVED       = 3'd5;
    localparam logic [FAIL_W-1:0] FAIL_HALL_BACK   = 3'd6;

    // Sub-phases; calibration uses all four, retry the first two
    localparam logic [PHASE_W-1:0] PH_START       = 2'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN_RUN    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SETTLE      = 2'd2;
    localparam logic [PHASE_W-1:0] PH_CLOSE_RUN   = 2'd3;
    localparam logic [PHASE_W-1:0] PH_RETRY_WAIT  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RETRY_DELAY = 2'd1;

    // Configuration register indexes (paddr bit 2) and reset values in ticks
    localparam logic REG_RETRY_DELAY = 1'b0;
    localparam logic REG_SETTLE      = 1'b1;
    localparam logic [DELAY_W-1:0] RETRY_DELAY_RESET = 16'd1000;
    localparam logic [DELAY_W-1:0] SETTLE_RESET      = 16'd50;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [PHASE_W-1:0] phase;
        logic               calibrated;
        logic [DELAY_W-1:0] delay;
    } ctrl_t;

endpackage

/* design/dlc_step_logic.sv */
// ============================================================================
// Door lock controller step logic
// Next controller state and motor command for one event.
// ============================================================================
module dlc_step_logic
    import dlc_pkg::*;
(
    input  ctrl_t              cur,
    input  logic [MODE_W-1:0]  mode,
    input  logic [ACT_W-1:0]   action,
    input  logic [FAIL_W-1:0]  failure,
    input  logic               door_pressed,
    input  logic               lock_pressed,
    input  logic [DELAY_W-1:0] retry_delay_ticks,
    input  logic [DELAY_W-1:0] settle_ticks,
    output ctrl_t              nxt,
    output logic [CMD_W-1:0]   motor_command
);

    // Enter a new state: sub-phase and delay start over
    function automatic ctrl_t enter(input ctrl_t c, input logic [STATE_W-1:0] s);
        ctrl_t r;
        r       = c;
        r.state = s;
        r.phase = PH_START;
        r.delay = '0;
        return r;
    endfunction

    logic [DELAY_W-1:0] delay_dec;
    logic               delay_done;
    logic               short_or_long;
    ctrl_t              close_nxt;
    logic [CMD_W-1:0]   close_cmd;

    always_comb
    begin
        delay_dec     = (cur.delay != '0) ? (cur.delay - 1'b1) : '0;
        delay_done    = (delay_dec == '0);
        short_or_long = (action == ACT_SHORT) || (action == ACT_LONG);

        // Start closing; an uncalibrated lock calibrates first
        close_nxt = cur.calibrated ? enter(cur, ST_CLOSING) : enter(cur, ST_CALIB);
        close_cmd = cur.calibrated ? CMD_CLOSE : CMD_NONE;

        nxt           = cur;
        motor_command = CMD_NONE;

        unique case (mode)
            MODE_TICK:
            begin
                unique case (cur.state)
                    ST_INIT:
                    begin
                        nxt = enter(cur, door_pressed ? ST_CALIB : ST_OPENED);
                        motor_command = CMD_UNFREEZE;
                    end
                    ST_WANT:
                    begin
                        if (door_pressed)
                        begin
                            nxt           = close_nxt;
                            motor_command = close_cmd;
                        end
                    end
                    ST_RETRY:
                    begin
                        if (cur.phase == PH_RETRY_DELAY)
                        begin
                            nxt.delay = delay_dec;
                            if (delay_done)
                                nxt = enter(cur, ST_WANT);
                        end
                    end
                    ST_CALIB:
                    begin
                        unique case (cur.phase)
                            PH_START:
                            begin
                                if (!lock_pressed)
                                begin
                                    nxt.phase     = PH_OPEN_RUN;
                                    motor_command = CMD_CAL_OPEN;
                                end
                                else
                                begin
                                    nxt.phase     = PH_CLOSE_RUN;
                                    motor_command = CMD_CAL;
                                end
                            end
                            PH_OPEN_RUN:
                            begin
                                if (lock_pressed)
                                begin
                                    nxt.phase     = PH_SETTLE;
                                    nxt.delay     = settle_ticks;
                                    motor_command = CMD_CAL_ABORT;
                                end
                            end
                            PH_SETTLE:
                            begin
                                nxt.delay = delay_dec;
                                if (delay_done)
                                begin
                                    nxt.phase     = PH_CLOSE_RUN;
                                    motor_command = CMD_CAL;
                                end
                            end
                            default:
                            begin
                                if (!lock_pressed)
                                begin
                                    nxt            = enter(cur, ST_CLOSED);
                                    nxt.calibrated = 1'b1;
                                    motor_command  = CMD_CAL_DONE;
                                end
                            end
                        endcase
                    end
                    ST_FATAL:
                        motor_command = CMD_FREEZE;
                    default:
                        ;
                endcase
            end

            MODE_OPEN:
            begin
                if (action == ACT_SHORT && cur.state == ST_FATAL)
                    nxt = enter(cur, ST_INIT);
                else if (short_or_long)
                begin
                    unique case (cur.state) inside
                        ST_CLOSED, ST_WARN:
                        begin
                            nxt           = enter(cur, ST_OPENING);
                            motor_command = CMD_OPEN;
                        end
                        ST_CLOSING:
                        begin
                            nxt           = enter(cur, ST_OPENING);
                            motor_command = CMD_REV_CLOSE;
                        end
                        ST_WANT:
                            nxt = enter(cur, ST_OPENED);
                        default:
                            ;
                    endcase
                end
                else if (action == ACT_SUPER && cur.state == ST_FATAL)
                begin
                    nxt           = enter(cur, ST_MAN_OPEN);
                    motor_command = CMD_MAN_OPEN;
                end
                else if (action == ACT_RELEASED && cur.state == ST_MAN_OPEN)
                begin
                    nxt           = enter(cur, ST_FATAL);
                    motor_command = CMD_MAN_END;
                end
            end

            MODE_CLOSE:
            begin
                if (action == ACT_SHORT && cur.state == ST_FATAL)
                    nxt = enter(cur, ST_INIT);
                else if (short_or_long)
                begin
                    unique case (cur.state)
                        ST_OPENED:
                        begin
                            if (door_pressed)
                            begin
                                nxt           = close_nxt;
                                motor_command = close_cmd;
                            end
                            else
                                nxt = enter(cur, ST_WANT);
                        end
                        ST_WARN:
                        begin
                            if (door_pressed)
                            begin
                                nxt           = enter(cur, ST_CLOSING);
                                motor_command = CMD_CLOSE;
                            end
                            else
                                nxt = enter(cur, ST_WANT);
                        end
                        ST_OPENING:
                        begin
                            nxt           = enter(cur, ST_CLOSING);
                            motor_command = CMD_REV_OPEN;
                        end
                        default:
                            ;
                    endcase
                end
                else if (action == ACT_SUPER && cur.state == ST_FATAL)
                begin
                    nxt           = enter(cur, ST_MAN_CLOSE);
                    motor_command = CMD_MAN_CLOSE;
                end
                else if (action == ACT_RELEASED && cur.state == ST_MAN_CLOSE)
                begin
                    nxt           = enter(cur, ST_FATAL);
                    motor_command = CMD_MAN_END;
                end
            end

            MODE_DOOR:
            begin
                if (action == ACT_LONG && cur.state == ST_WANT)
                begin
                    nxt           = close_nxt;
                    motor_command = close_cmd;
                end
                else if (action == ACT_RELEASED && cur.state == ST_CLOSING)
                begin
                    nxt           = enter(cur, ST_RETRY);
                    motor_command = CMD_REV_CLOSE;
                end
            end

            MODE_LOCK:
            begin
                if (cur.state == ST_CALIB)
                begin
                    if (action == ACT_RELEASED && cur.phase == PH_CLOSE_RUN)
                    begin
                        nxt            = enter(cur, ST_CLOSED);
                        nxt.calibrated = 1'b1;
                        motor_command  = CMD_CAL_DONE;
                    end
                    else if (short_or_long && cur.phase == PH_OPEN_RUN)
                    begin
                        nxt.phase     = PH_SETTLE;
                        nxt.delay     = settle_ticks;
                        motor_command = CMD_CAL_ABORT;
                    end
                end
            end

            MODE_MOTOR:
            begin
                case (failure) inside
                    FAIL_NONE:
                    begin
                        if (cur.state == ST_OPENING)
                            nxt = enter(cur, ST_OPENED);
                        else if (cur.state == ST_CLOSING)
                            nxt = enter(cur, ST_CLOSED);
                        else if (cur.state == ST_RETRY && cur.phase == PH_RETRY_WAIT)
                        begin
                            nxt.phase = PH_RETRY_DELAY;
                            nxt.delay = retry_delay_ticks;
                        end
                        else if (cur.state == ST_FATAL)
                            nxt = enter(cur, ST_INIT);
                    end
                    FAIL_CALIB, FAIL_DRIVER:
                    begin
                        nxt           = enter(cur, ST_FATAL);
                        motor_command = CMD_REVOKE;
                    end
                    FAIL_HALL_SILENT:
                    begin
                        if (cur.state != ST_OPENING && cur.state != ST_CLOSING)
                            nxt = enter(cur, ST_WARN);
                    end
                    FAIL_STEP_LOSS, FAIL_MOVED:
                        nxt = enter(cur, ST_WARN);
                    FAIL_HALL_BACK:
                        nxt = enter(cur, ST_INIT);
                    default:
                        ;
                endcase
            end

            default:
                ;
        endcase
    end

endmodule

/* design/door_lock_controller_fsm_top.sv */
// ============================================================================
// Door lock controller top level
// Event-driven motorized lock controller with APB configuration.
// ============================================================================
// One event word per cycle unless the result side stalls: the event register
// feeds the step logic, and the controller state and result register update
// at the same edge, so the state loop (controller register -> step logic ->
// controller register) is the path that sets the rate. An accepted event
// waits in the event register until the result register is free; its result
// word then shows on the result port. Each event word yields exactly one
// result word: the motor command, the controller state after the event, and
// the calibrated flag. Delays (retry_delay_ticks, settle_ticks) count tick
// events, not clock cycles; a delay of N ends on tick max(N, 1) after it loads.
// Write the configuration registers only while no event is in flight.
// ============================================================================
`include "door_lock_controller_fsm_top_macros.svh"

module door_lock_controller_fsm_top
    import dlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // Event channel
    input  logic               event_valid,
    output logic               event_ready,
    input  logic [MODE_W-1:0]  mode,
    input  logic [ACT_W-1:0]   action,
    input  logic [FAIL_W-1:0]  failure,
    input  logic               door_pressed,
    input  logic               lock_pressed,

    // Result channel
    output logic               result_valid,
    input  logic               result_ready,
    output logic [CMD_W-1:0]   motor_command,
    output logic [STATE_W-1:0] lock_state,
    output logic               calibrated,

    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0] retry_delay_reg;
    logic [DELAY_W-1:0] settle_reg;
    logic               cfg_write;

    // Decode on address bit 2 only; the low bits select nothing
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_RETRY_DELAY: prdata = {16'b0, retry_delay_reg};
            REG_SETTLE:      prdata = {16'b0, settle_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_delay_reg <= RETRY_DELAY_RESET;
            settle_reg      <= SETTLE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_RETRY_DELAY)
                retry_delay_reg <= pwdata[DELAY_W-1:0];
            else
                settle_reg <= pwdata[DELAY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: event register and result register, each one word deep
    // ------------------------------------------------------------------
    logic               ev_valid_reg;
    logic               ev_valid_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    logic               advance;

    logic [MODE_W-1:0]  mode_reg;
    logic [ACT_W-1:0]   action_reg;
    logic [FAIL_W-1:0]  failure_reg;
    logic               door_reg;
    logic               lock_reg;

    // Advance the held event into the result register when that slot frees up
    assign advance     = ev_valid_reg && (!result_valid_reg || result_ready);
    // Take a new word whenever the event register empties this cycle
    assign event_ready = !ev_valid_reg || advance;

    always_comb
    begin
        if (event_valid && event_ready)
            ev_valid_next = 1'b1;
        else if (advance)
            ev_valid_next = 1'b0;
        else
            ev_valid_next = ev_valid_reg;

        if (advance)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // ------------------------------------------------------------------
    // Controller state and step logic
    // ------------------------------------------------------------------
    ctrl_t              ctrl_reg;
    ctrl_t              ctrl_next;
    logic [CMD_W-1:0]   cmd_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [STATE_W-1:0] state_out_reg;
    logic               calib_out_reg;

    dlc_step_logic u_step (
        .cur               (ctrl_reg),
        .mode              (mode_reg),
        .action            (action_reg),
        .failure           (failure_reg),
        .door_pressed      (door_reg),
        .lock_pressed      (lock_reg),
        .retry_delay_ticks (retry_delay_reg),
        .settle_ticks      (settle_reg),
        .nxt               (ctrl_next),
        .motor_command     (cmd_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            ctrl_reg         <= '{state: ST_INIT, phase: PH_START,
                                  calibrated: 1'b0, delay: '0};
        end
        else
        begin
            ev_valid_reg     <= ev_valid_next;
            result_valid_reg <= result_valid_next;
            // Commit the state only when its event moves on to the result side
            if (advance)
                ctrl_reg <= ctrl_next;
        end
    end

    // Payload: hold the event word until it advances, hold the result until taken
    always_ff @(posedge clk)
    begin
        if (event_valid && event_ready)
        begin
            mode_reg    <= mode;
            action_reg  <= action;
            failure_reg <= failure;
            door_reg    <= door_pressed;
            lock_reg    <= lock_pressed;
        end
        if (advance)
        begin
            cmd_reg       <= cmd_next;
            state_out_reg <= ctrl_next.state;
            calib_out_reg <= ctrl_next.calibrated;
        end
    end

    assign result_valid  = result_valid_reg;
    assign motor_command = cmd_reg;
    assign lock_state    = state_out_reg;
    assign calibrated    = calib_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DLC_ASSERT_NEXT(a_calib_sticky, ctrl_reg.calibrated, ctrl_reg.calibrated)
    `DLC_ASSERT_SAME(a_stall_blocks, ev_valid_reg && result_valid_reg && !result_ready, !event_ready)
    `DLC_ASSERT_SAME(a_result_tracks_state, result_valid_reg, lock_state == ctrl_reg.state && calibrated == ctrl_reg.calibrated)
    `DLC_ASSERT_SAME(a_delay_idle, ctrl_reg.state != ST_RETRY && ctrl_reg.state != ST_CALIB, ctrl_reg.delay == '0)

endmodule

/* tb/sv/tb_door_lock_controller_fsm_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// Door lock controller testbench
// Drives event words through the controller and scores every result word
// against an in-bench model of the lock state machine: a short scripted
// walk through calibration, close, retry, fatal and manual modes, then
// state-steered random traffic under several delay settings with random
// sender bursts, receiver stalls and one long receiver hold-off.
// ============================================================================
module tb_door_lock_controller_fsm_top;
    import dlc_pkg::*;

    // Event kinds and motor results the controller must ignore
    localparam logic [MODE_W-1:0] MODE_SPARE  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam logic [FAIL_W-1:0] FAIL_UNUSED = 3'd7;

    // Register byte addresses: index times four
    localparam logic [2:0] ADDR_RETRY  = {REG_RETRY_DELAY, 2'b00};
    localparam logic [2:0] ADDR_SETTLE = {REG_SETTLE, 2'b00};

    // Cycles the receiver holds off to back the controller up into its input
    localparam int HOLD_CYCLES = 160;
    localparam int PHASES      = 5;
    localparam int SCRIPT_LEN  = 27;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ACT_W-1:0]  action;
        logic [FAIL_W-1:0] failure;
        logic              door;
        logic              lock;
    } lock_event_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [STATE_W-1:0] state;
        logic               cal;
    } lock_result_t;

    // known = 1: the result is typed in; known = 0: the model supplies it
    typedef struct packed {
        lock_event_t  ev;
        logic         known;
        lock_result_t res;
    } script_row_t;

    logic               clk;
    logic               rst_n;
    logic               event_valid;
    logic               event_ready;
    logic [MODE_W-1:0]  mode;
    logic [ACT_W-1:0]   action;
    logic [FAIL_W-1:0]  failure;
    logic               door_pressed;
    logic               lock_pressed;
    logic               result_valid;
    logic               result_ready;
    logic [CMD_W-1:0]   motor_command;
    logic [STATE_W-1:0] lock_state;
    logic               calibrated;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Model state: controller, sub-phase, calibrated flag, tick delay, registers
    logic [STATE_W-1:0] lk_state;
    logic [PHASE_W-1:0] lk_phase;
    logic               lk_cal;
    logic [DELAY_W-1:0] lk_delay;
    logic [DELAY_W-1:0] cfg_retry;
    logic [DELAY_W-1:0] cfg_settle;

    lock_result_t due_results[$];
    int unsigned  mismatches = 0;
    bit           hold_results = 1'b0;

    // Delay settings per random phase: both extremes and a few short ones so
    // that the retry and settle delays actually run out under random ticks
    logic [DELAY_W-1:0] retry_set  [PHASES] = '{16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd2};
    logic [DELAY_W-1:0] settle_set [PHASES] = '{16'd0, 16'd2, 16'hFFFF, 16'd5, 16'd1};
    int unsigned        word_count [PHASES] = '{160, 150, 60, 160, 160};
    int unsigned        gap_max    [PHASES] = '{0, 6, 3, 8, 4};

    // Scripted walk, run with retry delay 2 and settle delay 1
    script_row_t script [SCRIPT_LEN] = '{
        // unused event kind and unused motor result: nothing moves
        '{'{MODE_UNUSED, ACT_RELEASED, FAIL_UNUSED, 1'b1, 1'b1}, 1'b1,
          '{CMD_NONE, ST_INIT, 1'b0}},
        '{'{MODE_MOTOR, ACT_SHORT, FAIL_UNUSED, 1'b0, 1'b0}, 1'b1,
          '{CMD_NONE, ST_INIT, 1'b0}},
        // start-up with the door closed goes straight to calibration
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_UNFREEZE, ST_CALIB, 1'b0}},
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_CAL_OPEN, ST_CALIB, 1'b0}},
        // opening run ends on a tick that already sees the bolt switch pressed
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b1, 1'b1}, 1'b1,
          '{CMD_CAL_ABORT, ST_CALIB, 1'b0}},
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b1, 1'b1}, 1'b0, '0},
        // closing run ends on a tick that sees the switch released
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_CAL_DONE, ST_CLOSED, 1'b1}},
        '{'{MODE_OPEN, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_OPEN, ST_OPENING, 1'b1}},
        '{'{MODE_CLOSE, ACT_LONG, FAIL_NONE, 1'b0, 1'b0}, 1'b0, '0},
        // door opened while locking: revert, wait for the motor, then retry
        '{'{MODE_DOOR, ACT_RELEASED, FAIL_NONE, 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_MOTOR, ACT_SHORT, FAIL_NONE, 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_DOOR, ACT_LONG, FAIL_NONE, 1'b1, 1'b0}, 1'b0, '0},
        // hall silent while the motor runs is ignored
        '{'{MODE_MOTOR, ACT_SHORT, FAIL_HALL_SILENT, 1'b1, 1'b0}, 1'b0, '0},
        '{'{MODE_MOTOR, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b0, '0},
        '{'{MODE_MOTOR, ACT_SHORT, FAIL_MOVED, 1'b1, 1'b0}, 1'b0, '0},
        // close from warning with the door open defers the close
        '{'{MODE_CLOSE, ACT_SHORT, FAIL_NONE, 1'b0, 1'b0}, 1'b0, '0},
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b0, '0},
        // revoked calibration keeps the calibrated flag
        '{'{MODE_MOTOR, ACT_SHORT, FAIL_CALIB, 1'b1, 1'b0}, 1'b1,
          '{CMD_REVOKE, ST_FATAL, 1'b1}},
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_FREEZE, ST_FATAL, 1'b1}},
        '{'{MODE_OPEN, ACT_SUPER, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_MAN_OPEN, ST_MAN_OPEN, 1'b1}},
        '{'{MODE_OPEN, ACT_RELEASED, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_MAN_END, ST_FATAL, 1'b1}},
        '{'{MODE_CLOSE, ACT_SUPER, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_MAN_CLOSE, ST_MAN_CLOSE, 1'b1}},
        '{'{MODE_CLOSE, ACT_RELEASED, FAIL_NONE, 1'b1, 1'b0}, 1'b1,
          '{CMD_MAN_END, ST_FATAL, 1'b1}},
        '{'{MODE_MOTOR, ACT_SHORT, FAIL_NONE, 1'b1, 1'b0}, 1'b0, '0},
        '{'{MODE_TICK, ACT_SHORT, FAIL_NONE, 1'b0, 1'b0}, 1'b1,
          '{CMD_UNFREEZE, ST_OPENED, 1'b1}}
    };

    door_lock_controller_fsm_top u_dut (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Lock state model
    // ------------------------------------------------------------------------

    // Any state change drops the sub-phase and the running delay.
    function automatic void enter(input logic [STATE_W-1:0] s);
        lk_state = s;
        lk_phase = PH_START;
        lk_delay = '0;
    endfunction

    // Close request with the door against its switch: lock, or calibrate first.
    function automatic logic [CMD_W-1:0] begin_close();
        if (lk_cal)
        begin
            enter(ST_CLOSING);
            return CMD_CLOSE;
        end
        enter(ST_CALIB);
        return CMD_NONE;
    endfunction

    // Count one tick off the running delay; true once it has run out.
    function automatic logic delay_expired();
        if (lk_delay != '0)
            lk_delay = lk_delay - 1'b1;
        return lk_delay == '0;
    endfunction

    function automatic lock_result_t advance_lock(input lock_event_t w);
        logic [CMD_W-1:0] cmd;
        cmd = CMD_NONE;
        case (w.mode)
            MODE_TICK:
                case (lk_state)
                    ST_INIT:
                    begin
                        enter(w.door ? ST_CALIB : ST_OPENED);
                        cmd = CMD_UNFREEZE;
                    end
                    ST_WANT:
                        if (w.door)
                            cmd = begin_close();
                    ST_RETRY:
                        if (lk_phase == PH_RETRY_DELAY && delay_expired())
                            enter(ST_WANT);
                    ST_CALIB:
                        case (lk_phase)
                            PH_START:
                                if (!w.lock)
                                begin
                                    lk_phase = PH_OPEN_RUN;
                                    cmd = CMD_CAL_OPEN;
                                end
                                else
                                begin
                                    lk_phase = PH_CLOSE_RUN;
                                    cmd = CMD_CAL;
                                end
                            PH_OPEN_RUN:
                                if (w.lock)
                                begin
                                    lk_phase = PH_SETTLE;
                                    lk_delay = cfg_settle;
                                    cmd = CMD_CAL_ABORT;
                                end
                            PH_SETTLE:
                                if (delay_expired())
                                begin
                                    lk_phase = PH_CLOSE_RUN;
                                    cmd = CMD_CAL;
                                end
                            default:
                                if (!w.lock)
                                begin
                                    lk_cal = 1'b1;
                                    enter(ST_CLOSED);
                                    cmd = CMD_CAL_DONE;
                                end
                        endcase
                    ST_FATAL:
                        cmd = CMD_FREEZE;
                    default: ;
                endcase
            MODE_OPEN:
                if (w.action == ACT_SHORT && lk_state == ST_FATAL)
                    enter(ST_INIT);
                else if (w.action <= ACT_LONG)
                begin
                    case (lk_state)
                        ST_CLOSED, ST_WARN:
                        begin
                            enter(ST_OPENING);
                            cmd = CMD_OPEN;
                        end
                        ST_CLOSING:
                        begin
                            enter(ST_OPENING);
                            cmd = CMD_REV_CLOSE;
                        end
                        ST_WANT:
                            enter(ST_OPENED);
                        default: ;
                    endcase
                end
                else if (w.action == ACT_SUPER && lk_state == ST_FATAL)
                begin
                    enter(ST_MAN_OPEN);
                    cmd = CMD_MAN_OPEN;
                end
                else if (w.action == ACT_RELEASED && lk_state == ST_MAN_OPEN)
                begin
                    enter(ST_FATAL);
                    cmd = CMD_MAN_END;
                end
            MODE_CLOSE:
                if (w.action == ACT_SHORT && lk_state == ST_FATAL)
                    enter(ST_INIT);
                else if (w.action <= ACT_LONG)
                begin
                    case (lk_state)
                        ST_OPENED:
                            if (w.door)
                                cmd = begin_close();
                            else
                                enter(ST_WANT);
                        ST_WARN:
                            if (w.door)
                            begin
                                enter(ST_CLOSING);
                                cmd = CMD_CLOSE;
                            end
                            else
                                enter(ST_WANT);
                        ST_OPENING:
                        begin
                            enter(ST_CLOSING);
                            cmd = CMD_REV_OPEN;
                        end
                        default: ;
                    endcase
                end
                else if (w.action == ACT_SUPER && lk_state == ST_FATAL)
                begin
                    enter(ST_MAN_CLOSE);
                    cmd = CMD_MAN_CLOSE;
                end
                else if (w.action == ACT_RELEASED && lk_state == ST_MAN_CLOSE)
                begin
                    enter(ST_FATAL);
                    cmd = CMD_MAN_END;
                end
            MODE_DOOR:
                if (w.action == ACT_LONG && lk_state == ST_WANT)
                    cmd = begin_close();
                else if (w.action == ACT_RELEASED && lk_state == ST_CLOSING)
                begin
                    enter(ST_RETRY);
                    cmd = CMD_REV_CLOSE;
                end
            MODE_LOCK:
                if (lk_state == ST_CALIB)
                begin
                    if (w.action == ACT_RELEASED && lk_phase == PH_CLOSE_RUN)
                    begin
                        lk_cal = 1'b1;
                        enter(ST_CLOSED);
                        cmd = CMD_CAL_DONE;
                    end
                    else if (w.action <= ACT_LONG && lk_phase == PH_OPEN_RUN)
                    begin
                        lk_phase = PH_SETTLE;
                        lk_delay = cfg_settle;
                        cmd = CMD_CAL_ABORT;
                    end
                end
            MODE_MOTOR:
                case (w.failure)
                    FAIL_NONE:
                        if (lk_state == ST_OPENING)
                            enter(ST_OPENED);
                        else if (lk_state == ST_CLOSING)
                            enter(ST_CLOSED);
                        else if (lk_state == ST_RETRY && lk_phase == PH_RETRY_WAIT)
                        begin
                            lk_phase = PH_RETRY_DELAY;
                            lk_delay = cfg_retry;
                        end
                        else if (lk_state == ST_FATAL)
                            enter(ST_INIT);
                    FAIL_CALIB, FAIL_DRIVER:
                    begin
                        enter(ST_FATAL);
                        cmd = CMD_REVOKE;
                    end
                    FAIL_HALL_SILENT:
                        if (lk_state != ST_OPENING && lk_state != ST_CLOSING)
                            enter(ST_WARN);
                    FAIL_STEP_LOSS, FAIL_MOVED:
                        enter(ST_WARN);
                    FAIL_HALL_BACK:
                        enter(ST_INIT);
                    default: ;
                endcase
            default: ;
        endcase
        return '{cmd, lk_state, lk_cal};
    endfunction

    // ------------------------------------------------------------------------
    // Random event source: mostly the event that moves the current state on,
    // with 17 in 100 plain random events and a few unused codes as noise
    // ------------------------------------------------------------------------
    function automatic lock_event_t next_word();
        lock_event_t w;
        int unsigned roll;
        int unsigned steer;
        w.mode    = MODE_W'($urandom_range(MODE_TICK, MODE_MOTOR));
        w.action  = ACT_W'($urandom_range(0, 3));
        w.failure = FAIL_W'($urandom_range(FAIL_NONE, FAIL_HALL_BACK));
        w.door    = 1'($urandom_range(0, 1));
        w.lock    = 1'($urandom_range(0, 1));
        roll      = $urandom_range(0, 99);
        steer     = $urandom_range(0, 99);
        if (roll < 3)
            w.mode = (steer < 50) ? MODE_SPARE : MODE_UNUSED;
        else if (roll < 5)
        begin
            w.mode    = MODE_MOTOR;
            w.failure = FAIL_UNUSED;
        end
        else if (roll >= 22)
        begin
            w.failure = FAIL_NONE;
            case (lk_state)
                ST_INIT:
                    w.mode = MODE_TICK;
                ST_OPENED:
                begin
                    w.mode   = (steer < 75) ? MODE_CLOSE : MODE_TICK;
                    w.action = ACT_W'($urandom_range(ACT_SHORT, ACT_LONG));
                end
                ST_CLOSED:
                begin
                    w.mode   = (steer < 60) ? MODE_OPEN : MODE_TICK;
                    w.action = ACT_W'($urandom_range(ACT_SHORT, ACT_LONG));
                end
                ST_OPENING:
                begin
                    w.mode   = (steer < 60) ? MODE_MOTOR : (steer < 80) ? MODE_CLOSE : MODE_TICK;
                    w.action = ACT_W'($urandom_range(ACT_SHORT, ACT_LONG));
                end
                ST_CLOSING:
                    if (steer < 55)
                        w.mode = MODE_MOTOR;
                    else if (steer < 75)
                    begin
                        w.mode   = MODE_DOOR;
                        w.action = ACT_RELEASED;
                    end
                    else if (steer < 90)
                    begin
                        w.mode   = MODE_OPEN;
                        w.action = ACT_W'($urandom_range(ACT_SHORT, ACT_LONG));
                    end
                    else
                    begin
                        w.mode    = MODE_MOTOR;
                        w.failure = FAIL_HALL_SILENT;
                    end
                ST_WANT:
                    if (steer < 50)
                        w.mode = MODE_TICK;
                    else if (steer < 75)
                    begin
                        w.mode   = MODE_DOOR;
                        w.action = ACT_LONG;
                    end
                    else
                    begin
                        w.mode   = MODE_OPEN;
                        w.action = ACT_W'($urandom_range(ACT_SHORT, ACT_LONG));
                    end
                ST_RETRY:
                    if (lk_phase == PH_RETRY_WAIT && steer < 70)
                        w.mode = MODE_MOTOR;
                    else
                        w.mode = MODE_TICK;
                ST_CALIB:
                    case (lk_phase)
                        PH_OPEN_RUN:
                            if (steer < 60)
                                w.mode = MODE_TICK;
                            else
                            begin
                                w.mode   = MODE_LOCK;
                                w.action = ACT_W'($urandom_range(ACT_SHORT, ACT_LONG));
                            end
                        PH_CLOSE_RUN:
                            if (steer < 60)
                                w.mode = MODE_TICK;
                            else
                            begin
                                w.mode   = MODE_LOCK;
                                w.action = ACT_RELEASED;
                            end
                        default:
                            w.mode = MODE_TICK;
                    endcase
                ST_WARN:
                begin
                    w.mode   = (steer < 50) ? MODE_OPEN : MODE_CLOSE;
                    w.action = ACT_W'($urandom_range(ACT_SHORT, ACT_LONG));
                end
                ST_FATAL:
                    case ($urandom_range(0, 3))
                        0:       w.mode = MODE_TICK;
                        1:       w.mode = MODE_OPEN;
                        2:       w.mode = MODE_CLOSE;
                        default: w.mode = MODE_MOTOR;
                    endcase
                ST_MAN_OPEN:
                begin
                    w.mode = MODE_OPEN;
                    if (steer < 70)
                        w.action = ACT_RELEASED;
                end
                ST_MAN_CLOSE:
                begin
                    w.mode = MODE_CLOSE;
                    if (steer < 70)
                        w.action = ACT_RELEASED;
                end
                default: ;
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Event sender and configuration port
    // ------------------------------------------------------------------------

    // Offer one word, hold it until accepted, then run the model on it.
    // Call at a rising edge; returns at the edge where the word was taken.
    task automatic push_word(input lock_event_t w, input logic known,
                             input lock_result_t typed);
        lock_result_t predicted;
        event_valid  <= 1'b1;
        mode         <= w.mode;
        action       <= w.action;
        failure      <= w.failure;
        door_pressed <= w.door;
        lock_pressed <= w.lock;
        @(posedge clk);
        while (!event_ready)
            @(posedge clk);
        predicted = advance_lock(w);
        due_results.push_back(known ? typed : predicted);
    endtask

    // Drop valid, wait for every pending result, then idle on before returning.
    task automatic wait_idle();
        event_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Setup then access; the write lands on the access edge.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [2:0] addr, input logic [DELAY_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {16'b0, want})
            note_mismatch("register read", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write both delays, mirror them in the model, and read them back.
    task automatic program_delays(input logic [DELAY_W-1:0] retry,
                                  input logic [DELAY_W-1:0] settle);
        apb_write(ADDR_RETRY, {16'b0, retry});
        cfg_retry = retry;
        apb_write(ADDR_SETTLE, {16'b0, settle});
        cfg_settle = settle;
        check_register(ADDR_RETRY, retry);
        check_register(ADDR_SETTLE, settle);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: switches between always-ready stretches and runs of
    // random-length ready/stall, and on request holds off for a long stretch
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned run_left;
        int unsigned style_left;
        logic        level;
        logic        paced;
        run_left     = 0;
        style_left   = 0;
        level        = 1'b1;
        paced        = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
                result_ready <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    paced      = 1'($urandom_range(0, 1));
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                if (run_left == 0)
                begin
                    level    = !level;
                    run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                run_left--;
                result_ready <= paced ? level : 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: each taken result word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : score_results
        lock_result_t due;
        if (rst_n && result_valid && result_ready)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result word with nothing pending: cmd %0d state %0d",
                             $time, motor_command, lock_state);
            end
            else
            begin
                due = due_results.pop_front();
                if (motor_command !== due.cmd)
                    note_mismatch("motor_command", due.cmd, motor_command);
                if (lock_state !== due.state)
                    note_mismatch("lock_state", due.state, lock_state);
                if (calibrated !== due.cal)
                    note_mismatch("calibrated", due.cal, calibrated);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned p;
        int unsigned n;
        int unsigned burst;
        int unsigned gap;

        // Hold every input at a known level from time zero
        rst_n        = 1'b0;
        event_valid  = 1'b0;
        mode         = MODE_TICK;
        action       = ACT_SHORT;
        failure      = FAIL_NONE;
        door_pressed = 1'b0;
        lock_pressed = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        lk_state   = ST_INIT;
        lk_phase   = PH_START;
        lk_cal     = 1'b0;
        lk_delay   = '0;
        cfg_retry  = RETRY_DELAY_RESET;
        cfg_settle = SETTLE_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers come out of reset at their default delays
        check_register(ADDR_RETRY, RETRY_DELAY_RESET);
        check_register(ADDR_SETTLE, SETTLE_RESET);

        // Scripted walk with short delays so the retry and settle paths finish
        program_delays(16'd2, 16'd1);
        for (n = 0; n < SCRIPT_LEN; n++)
            push_word(script[n].ev, script[n].known, script[n].res);
        wait_idle();

        // Random phases, one delay setting each; registers change only idle
        for (p = 0; p < PHASES; p++)
        begin
            program_delays(retry_set[p], settle_set[p]);

            // Back the controller up: receiver holds off, sender keeps going
            if (p == 3)
            begin
                hold_results = 1'b1;
                repeat (40) push_word(next_word(), 1'b0, '0);
            end

            burst = $urandom_range(1, 20);
            for (n = 0; n < word_count[p]; n++)
            begin
                // Halfway through, pause until the controller has drained
                if (n == word_count[p] / 2)
                    wait_idle();
                push_word(next_word(), 1'b0, '0);
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 20);
                    gap   = $urandom_range(0, gap_max[p]);
                    if (gap != 0)
                    begin
                        event_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/dlc_pkg.sv
design/dlc_step_logic.sv
design/door_lock_controller_fsm_top.sv
tb/sv/tb_door_lock_controller_fsm_top.sv
